>>> design/aitp_pkg.sv
// shared types and constants for the interrupt table parser
`default_nettype none
package aitp_pkg;

    localparam logic [31:0] WalkStart  = 32'd44;
    localparam int          FieldBytes = 10;
    localparam logic [9:0]  CpuMax     = 10'd1023;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIG   = 3'd1,
        ST_BAD_SUM   = 3'd2,
        ST_SHORT     = 3'd3,
        ST_ZERO_BASE = 3'd4
    } t_status;

    localparam logic [7:0] TypeCpu      = 8'd0;
    localparam logic [7:0] TypeIoUnit   = 8'd1;
    localparam logic [7:0] TypeOverride = 8'd2;
    localparam logic [7:0] TypeBase64   = 8'd5;

    // byte passed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_item;

    // result item
    typedef struct packed {
        t_status     status;
        logic [63:0] local_base;
        logic [9:0]  cpu_count;
        logic [7:0]  io_unit_id;
        logic [31:0] io_unit_base;
        logic [31:0] io_interrupt_base;
        logic        timer_override_seen;
        logic [31:0] timer_interrupt;
        logic [15:0] timer_override_flags;
    } t_result;

endpackage
`default_nettype wire

>>> design/aitp_front.sv
// input side: accepts byte transfers into a short queue
`default_nettype none
module aitp_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire aitp_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output aitp_pkg::t_item     o_item
);
    // two-entry queue
    aitp_pkg::t_item r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_item;
    end
endmodule
`default_nettype wire

>>> design/aitp_back.sv
// parse state: header checks, checksum, entry walk, result register
`default_nettype none
module aitp_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire aitp_pkg::t_item  i_item,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output aitp_pkg::t_result     o_result
);
    logic [31:0] r_off, r_len, r_start;
    logic [7:0]  r_sum, r_etype, r_elen;
    logic        r_sig, r_stop;
    logic [7:0]  r_fb [aitp_pkg::FieldBytes];
    logic [63:0] r_lbase;
    logic [9:0]  r_cpu;
    logic [7:0]  r_ioid;
    logic [31:0] r_iobase, r_ioirq, r_otgt;
    logic        r_oseen;
    logic [15:0] r_oflg;
    logic        r_ovalid;
    aitp_pkg::t_result r_res;

    logic [31:0] n_off, n_len, n_start;
    logic [7:0]  n_sum, n_etype, n_elen;
    logic        n_sig, n_stop;
    logic [7:0]  n_fb [aitp_pkg::FieldBytes];
    logic [63:0] n_lbase;
    logic [9:0]  n_cpu;
    logic [7:0]  n_ioid;
    logic [31:0] n_iobase, n_ioirq, n_otgt;
    logic        n_oseen;
    logic [15:0] n_oflg;
    aitp_pkg::t_result n_res;

    logic        w_take;
    logic [31:0] w_rel, w_relm2, w_off;
    logic        w_fin;
    logic [7:0]  w_b;
    logic [7:0]  w_sig_byte;
    logic [32:0] w_end;
    logic [32:0] w_cnt;

    assign o_ready  = !r_ovalid || i_ready;
    assign w_take   = i_valid && o_ready;
    assign o_valid  = r_ovalid;
    assign o_result = r_res;

    // next parse state for one byte
    always_comb begin
        n_off = r_off; n_len = r_len; n_start = r_start; n_sum = r_sum;
        n_etype = r_etype; n_elen = r_elen; n_sig = r_sig; n_stop = r_stop;
        n_fb = r_fb; n_lbase = r_lbase; n_cpu = r_cpu; n_ioid = r_ioid;
        n_iobase = r_iobase; n_ioirq = r_ioirq; n_otgt = r_otgt;
        n_oseen = r_oseen; n_oflg = r_oflg;
        w_b = i_item.data;
        w_fin = 1'b0;
        w_end = 33'd0;
        w_sig_byte = 8'h41;
        if (i_item.first) begin
            n_off = '0; n_len = '0; n_start = aitp_pkg::WalkStart; n_sum = '0;
            n_etype = '0; n_elen = '0; n_sig = 1'b1; n_stop = 1'b0;
            for (int k = 0; k < aitp_pkg::FieldBytes; k++) n_fb[k] = '0;
            n_lbase = '0; n_cpu = '0; n_ioid = '0; n_iobase = '0;
            n_ioirq = '0; n_otgt = '0; n_oseen = 1'b0; n_oflg = '0;
        end
        w_off = n_off;
        w_rel = w_off - n_start;
        w_relm2 = w_rel - 32'd2;
        // header fields
        if (w_off < 32'd4) begin
            case (w_off[1:0])
                2'd0: w_sig_byte = 8'h41;
                2'd1: w_sig_byte = 8'h50;
                2'd2: w_sig_byte = 8'h49;
                default: w_sig_byte = 8'h43;
            endcase
            if (w_b != w_sig_byte) n_sig = 1'b0;
        end else if (w_off < 32'd8) begin
            n_len[w_off[1:0]*8 +: 8] = w_b;
        end else if (w_off >= 32'd36 && w_off < 32'd40) begin
            if (w_off[1:0] == 2'd0) n_lbase = {56'd0, w_b};
            else n_lbase[w_off[1:0]*8 +: 8] = w_b;
        end
        if (w_off < 32'd8 || w_off < n_len) n_sum = n_sum + w_b;
        // entry walk
        if (!n_stop && w_off < n_len && w_off >= n_start) begin
            if (w_rel == 32'd0) begin
                n_etype = w_b;
                n_elen = '0;
                for (int k = 0; k < aitp_pkg::FieldBytes; k++) n_fb[k] = '0;
            end else if (w_rel == 32'd1) begin
                n_elen = w_b;
                w_end = {1'b0, n_start} + {25'd0, w_b};
                if (w_b < 8'd2 || w_end > {1'b0, n_len}) n_stop = 1'b1;
                else if (w_b == 8'd2) w_fin = 1'b1;
            end else begin
                if (w_relm2 < 32'(aitp_pkg::FieldBytes))
                    n_fb[w_relm2[3:0]] = w_b;
                if (w_rel == {24'd0, n_elen} - 32'd1) w_fin = 1'b1;
            end
        end
        // act on a finished entry
        if (w_fin) begin
            case (n_etype)
                aitp_pkg::TypeCpu:
                    if (n_fb[2][0] && n_cpu < aitp_pkg::CpuMax) n_cpu = n_cpu + 10'd1;
                aitp_pkg::TypeIoUnit:
                    if (r_iobase == 32'd0 || i_item.first) begin
                        if (n_iobase == 32'd0) begin
                            n_ioid   = n_fb[0];
                            n_iobase = {n_fb[5], n_fb[4], n_fb[3], n_fb[2]};
                            n_ioirq  = {n_fb[9], n_fb[8], n_fb[7], n_fb[6]};
                        end
                    end
                aitp_pkg::TypeOverride:
                    if (n_fb[1] == 8'd0) begin
                        n_oseen = 1'b1;
                        n_otgt  = {n_fb[5], n_fb[4], n_fb[3], n_fb[2]};
                        n_oflg  = {n_fb[7], n_fb[6]};
                    end
                aitp_pkg::TypeBase64:
                    n_lbase = {n_fb[9], n_fb[8], n_fb[7], n_fb[6],
                               n_fb[5], n_fb[4], n_fb[3], n_fb[2]};
                default: ;
            endcase
            n_start = n_start + {24'd0, n_elen};
        end
        if (n_off != 32'hFFFF_FFFF) n_off = n_off + 32'd1;
        // result
        w_cnt = {1'b0, n_off};
        if (!n_sig) n_res.status = aitp_pkg::ST_BAD_SIG;
        else if (w_cnt < 33'd8 || n_off < n_len) n_res.status = aitp_pkg::ST_SHORT;
        else if (n_sum != 8'd0) n_res.status = aitp_pkg::ST_BAD_SUM;
        else if (n_lbase == 64'd0) n_res.status = aitp_pkg::ST_ZERO_BASE;
        else n_res.status = aitp_pkg::ST_OK;
        n_res.local_base = n_lbase;
        n_res.cpu_count = n_cpu;
        n_res.io_unit_id = n_ioid;
        n_res.io_unit_base = n_iobase;
        n_res.io_interrupt_base = n_ioirq;
        n_res.timer_override_seen = n_oseen;
        n_res.timer_interrupt = n_otgt;
        n_res.timer_override_flags = n_oflg;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= '0; r_len <= '0; r_start <= aitp_pkg::WalkStart; r_sum <= '0;
            r_sig <= 1'b1; r_stop <= 1'b0; r_etype <= '0; r_elen <= '0;
            for (int k = 0; k < aitp_pkg::FieldBytes; k++) r_fb[k] <= '0;
            r_lbase <= '0; r_cpu <= '0; r_ioid <= '0; r_iobase <= '0;
            r_ioirq <= '0; r_oseen <= 1'b0; r_otgt <= '0; r_oflg <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_take) begin
                r_off <= n_off; r_len <= n_len; r_start <= n_start; r_sum <= n_sum;
                r_sig <= n_sig; r_stop <= n_stop; r_etype <= n_etype; r_elen <= n_elen;
                r_fb <= n_fb; r_lbase <= n_lbase; r_cpu <= n_cpu; r_ioid <= n_ioid;
                r_iobase <= n_iobase; r_ioirq <= n_ioirq; r_oseen <= n_oseen;
                r_otgt <= n_otgt; r_oflg <= n_oflg;
            end
            if (w_take) r_ovalid <= i_item.last;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_take && i_item.last) r_res <= n_res;
    end
endmodule
`default_nettype wire

>>> design/acpi_interrupt_table_parser_unit.sv
// Top level of the interrupt table parser.
// A last byte passes the input queue and then the result register before its result
// is valid. Throughput: one byte per cycle unless the output stalls; the back end
// updates all parse state for a byte combinationally.
// A two-entry queue separates input and parse, a result register the output.
// Reset (i_rst_n low, synchronous) empties queue and result and clears parse state.
`default_nettype none
module acpi_interrupt_table_parser_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,  // table_byte
    input  wire logic          s_axis_tuser,  // first_byte
    input  wire logic          s_axis_tlast,  // last_byte
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // status[2:0], local_base[66:3], cpu_count[76:67], io_unit_id[84:77],
    // io_unit_base[116:85], io_interrupt_base[148:117], timer_override_seen[149],
    // timer_interrupt[181:150], timer_override_flags[197:182], zero fill
    output logic [199:0]       m_axis_tdata
);
    aitp_pkg::t_item   w_in, w_q;
    aitp_pkg::t_result w_res;
    logic              w_qv, w_qr;

    assign w_in = '{data: s_axis_tdata, first: s_axis_tuser, last: s_axis_tlast};

    // input queue
    aitp_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_q)
    );

    // parser
    aitp_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qv), .o_ready(w_qr), .i_item(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_result(w_res)
    );

    // pack result, first field lowest
    assign m_axis_tdata = {2'b00, w_res.timer_override_flags, w_res.timer_interrupt,
                           w_res.timer_override_seen, w_res.io_interrupt_base,
                           w_res.io_unit_base, w_res.io_unit_id, w_res.cpu_count,
                           w_res.local_base, w_res.status};
endmodule
`default_nettype wire

>>> design/aitp_checker.sv
// port-level checks of the parser
`default_nettype none
module aitp_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [199:0] m_axis_tdata
);
    // result stays while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // status in range
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4)
        else $error("bad status code");
    // no result straight out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");
    // fill bits are zero
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[199:198] == 2'b00)
        else $error("fill bits set");
endmodule

bind acpi_interrupt_table_parser_unit aitp_checker u_aitp_checker (
    .i_clk, .i_rst_n,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

>>> dv/tb_acpi_interrupt_table_parser_unit.sv
// testbench for the interrupt table parser: directed and random tables checked against a local model
`default_nettype none
module tb_acpi_interrupt_table_parser_unit;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;  // table_byte
    logic         s_axis_tuser;  // first_byte
    logic         s_axis_tlast;  // last_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // status, local_base, cpu_count, io_unit_id, io_unit_base, io_interrupt_base,
    // timer_override_seen, timer_interrupt, timer_override_flags, zero fill
    logic [199:0] m_axis_tdata;

    acpi_interrupt_table_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // parser model state
    logic [31:0] mdl_offset;
    logic [31:0] mdl_length;
    logic [7:0]  mdl_sum;
    logic        mdl_sig_ok;
    logic        mdl_stopped;
    logic [31:0] mdl_entry_start;
    logic [7:0]  mdl_entry_type;
    logic [7:0]  mdl_entry_len;
    logic [7:0]  mdl_fields [aitp_pkg::FieldBytes];
    aitp_pkg::t_result mdl_acc;

    aitp_pkg::t_result summary_queue [$];
    int          error_count;
    int          items_sent;
    int          out_wait;
    byte         tbl [$];

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] field_value(int first, int count);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < count; i++)
            if (first + i < aitp_pkg::FieldBytes)
                v |= 64'(mdl_fields[first + i]) << (8 * i);
        return v;
    endfunction

    function automatic void clear_model();
        mdl_offset = '0;
        mdl_length = '0;
        mdl_sum = '0;
        mdl_sig_ok = 1'b1;
        mdl_stopped = 1'b0;
        mdl_entry_start = aitp_pkg::WalkStart;
        mdl_entry_type = '0;
        mdl_entry_len = '0;
        for (int i = 0; i < aitp_pkg::FieldBytes; i++) mdl_fields[i] = '0;
        mdl_acc = '0;
    endfunction

    // act on a completed entry and advance the walk
    function automatic void close_entry();
        case (mdl_entry_type)
            aitp_pkg::TypeCpu: begin
                if (mdl_fields[2][0] && mdl_acc.cpu_count < aitp_pkg::CpuMax)
                    mdl_acc.cpu_count++;
            end
            aitp_pkg::TypeIoUnit: begin
                if (mdl_acc.io_unit_base == 0) begin
                    mdl_acc.io_unit_id = mdl_fields[0];
                    mdl_acc.io_unit_base = 32'(field_value(2, 4));
                    mdl_acc.io_interrupt_base = 32'(field_value(6, 4));
                end
            end
            aitp_pkg::TypeOverride: begin
                if (mdl_fields[1] == 0) begin
                    mdl_acc.timer_override_seen = 1'b1;
                    mdl_acc.timer_interrupt = 32'(field_value(2, 4));
                    mdl_acc.timer_override_flags = 16'(field_value(6, 2));
                end
            end
            aitp_pkg::TypeBase64: mdl_acc.local_base = field_value(2, 8);
            default: ;
        endcase
        mdl_entry_start = mdl_entry_start + 32'(mdl_entry_len);
    endfunction

    // advance the model by one byte, queue a summary on a last byte
    function automatic void predict_byte(logic [7:0] b, logic first, logic last);
        logic [31:0] off;
        logic [31:0] rel;
        logic [31:0] sig;
        aitp_pkg::t_result r;
        if (first) clear_model();
        off = mdl_offset;
        sig = "APIC";
        if (off < 4) begin
            if (b != sig[8 * (3 - off) +: 8]) mdl_sig_ok = 1'b0;
        end else if (off < 8) begin
            mdl_length |= 32'(b) << (8 * (off - 4));
        end else if (off >= 36 && off < 40) begin
            if (off == 36) mdl_acc.local_base = 64'(b);
            else mdl_acc.local_base |= 64'(b) << (8 * (off - 36));
        end
        if (off < 8 || off < mdl_length) mdl_sum = mdl_sum + b;
        if (!mdl_stopped && off < mdl_length && off >= mdl_entry_start) begin
            rel = off - mdl_entry_start;
            if (rel == 0) begin
                mdl_entry_type = b;
                mdl_entry_len = '0;
                for (int i = 0; i < aitp_pkg::FieldBytes; i++) mdl_fields[i] = '0;
            end else if (rel == 1) begin
                mdl_entry_len = b;
                if (b < 2 || 33'(mdl_entry_start) + 33'(b) > 33'(mdl_length))
                    mdl_stopped = 1'b1;
                else if (b == 2)
                    close_entry();
            end else begin
                if (rel - 2 < aitp_pkg::FieldBytes) mdl_fields[rel - 2] = b;
                if (rel == 32'(mdl_entry_len) - 1) close_entry();
            end
        end
        if (mdl_offset != 32'hFFFF_FFFF) mdl_offset++;
        if (last) begin
            r = mdl_acc;
            if (!mdl_sig_ok) r.status = aitp_pkg::ST_BAD_SIG;
            else if (mdl_offset < 8 || mdl_offset < mdl_length) r.status = aitp_pkg::ST_SHORT;
            else if (mdl_sum != 0) r.status = aitp_pkg::ST_BAD_SUM;
            else if (mdl_acc.local_base == 0) r.status = aitp_pkg::ST_ZERO_BASE;
            else r.status = aitp_pkg::ST_OK;
            summary_queue.push_back(r);
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // send one byte, with a random gap before it
    task automatic send_byte(logic [7:0] b, logic first, logic last);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 1)) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_byte(b, first, last);
        items_sent++;
    endtask

    task automatic send_table();
        foreach (tbl[i]) send_byte(tbl[i], i == 0, i == tbl.size() - 1);
    endtask

    // fix length and checksum over the first n bytes
    function automatic void seal_table(int n);
        logic [7:0] s;
        tbl[4] = n[7:0]; tbl[5] = n[15:8]; tbl[6] = n[23:16]; tbl[7] = n[31:24];
        tbl[9] = 0;
        s = 0;
        for (int i = 0; i < n; i++) s += tbl[i];
        tbl[9] = -s;
    endfunction

    function automatic void start_table(logic [31:0] base);
        tbl.delete();
        tbl.push_back("A"); tbl.push_back("P"); tbl.push_back("I"); tbl.push_back("C");
        for (int i = 4; i < 44; i++) tbl.push_back(8'($urandom_range(0, 255)));
        tbl[36] = base[7:0]; tbl[37] = base[15:8];
        tbl[38] = base[23:16]; tbl[39] = base[31:24];
    endfunction

    function automatic void add_entry(logic [7:0] kind, int len, bit full_random);
        tbl.push_back(kind);
        tbl.push_back(8'(len));
        for (int i = 2; i < len; i++) begin
            logic [7:0] v;
            v = 8'($urandom_range(0, 255));
            if (!full_random && $urandom_range(0, 3) == 0) v = (i == 3) ? 8'h00 : 8'hFF;
            tbl.push_back(v);
        end
    endfunction

    // random table with mixed entries, well-formed unless a corruption is applied
    function automatic void build_random_table();
        int n;
        logic [7:0] kinds [5];
        kinds = '{aitp_pkg::TypeCpu, aitp_pkg::TypeIoUnit, aitp_pkg::TypeOverride,
                  aitp_pkg::TypeBase64, 8'd9};
        start_table($urandom_range(0, 7) == 0 ? 0 : $urandom());
        n = $urandom_range(0, 6);
        for (int k = 0; k < n; k++) begin
            logic [7:0] t;
            int len;
            t = kinds[$urandom_range(0, 4)];
            case (t)
                aitp_pkg::TypeCpu:
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 9) : 8;
                aitp_pkg::TypeIoUnit:
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 13) : 12;
                aitp_pkg::TypeOverride:
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 11) : 10;
                aitp_pkg::TypeBase64:
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 13) : 12;
                default:
                    len = $urandom_range(2, 6);
            endcase
            add_entry(t, len, 1'b0);
            if (t == aitp_pkg::TypeOverride && len > 3 && $urandom_range(0, 1))
                tbl[tbl.size() - len + 3] = 0;
        end
        seal_table(tbl.size());
        // corruptions and trailing bytes
        case ($urandom_range(0, 9))
            0: tbl[$urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
            1: tbl[$urandom_range(10, tbl.size() - 1)] ^= 8'h10;
            2: tbl = tbl[0:$urandom_range(0, tbl.size() - 2)];
            3: repeat ($urandom_range(1, 5)) tbl.push_back(8'($urandom_range(0, 255)));
            4: if (tbl.size() > 45) tbl[45] = 8'($urandom_range(0, 1));
            default: ;
        endcase
    endfunction

    task automatic test_directed();
        // minimal header-only tables, with a typical, zero and all-ones base
        start_table(32'hFEE0_0000); seal_table(44); send_table();
        start_table(0); seal_table(44); send_table();
        start_table(32'hFFFF_FFFF); seal_table(44); send_table();
        // one byte table and short header
        tbl = '{8'h41}; send_table();
        tbl = '{8'hFF, 8'h00, 8'h49}; send_table();
        // declared length below the header
        start_table(1); seal_table(3); send_table();
        // each entry type at full size, a second io unit, an override with nonzero source and a two-byte base entry
        start_table(32'h1234_5678);
        add_entry(aitp_pkg::TypeCpu, 8, 1'b0); tbl[tbl.size() - 4] = 8'h01;
        add_entry(aitp_pkg::TypeIoUnit, 12, 1'b1);
        add_entry(aitp_pkg::TypeIoUnit, 12, 1'b1);
        add_entry(aitp_pkg::TypeOverride, 10, 1'b1); tbl[tbl.size() - 7] = 0;
        add_entry(aitp_pkg::TypeOverride, 10, 1'b1); tbl[tbl.size() - 7] = 8'h05;
        add_entry(aitp_pkg::TypeBase64, 12, 1'b1);
        add_entry(aitp_pkg::TypeBase64, 2, 1'b1);
        seal_table(tbl.size()); send_table();
        // zero-length entry stops the walk, entry overrunning length
        start_table(5); add_entry(aitp_pkg::TypeCpu, 8, 1'b0); tbl[45] = 0;
        seal_table(tbl.size()); send_table();
        start_table(5); add_entry(aitp_pkg::TypeIoUnit, 12, 1'b1);
        seal_table(tbl.size() - 1); send_table();
        // continuation without a first mark
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b1);
    endtask

    // a table with bare, many enabled and some disabled cpu entries
    task automatic test_cpu_count();
        start_table(32'h0000_1000);
        repeat (4) begin
            add_entry(aitp_pkg::TypeCpu, 2, 1'b1);
        end
        repeat (36) begin
            add_entry(aitp_pkg::TypeCpu, 8, 1'b1); tbl[tbl.size() - 4] |= 8'h01;
        end
        for (int i = 0; i < 3; i++) begin
            add_entry(aitp_pkg::TypeCpu, 8, 1'b0); tbl[tbl.size() - 4] = 8'hFE;
        end
        seal_table(tbl.size());
        send_table();
    endtask

    task automatic test_random_tables();
        while (items_sent < 1850) begin
            build_random_table();
            send_table();
        end
    endtask

    // output stall and result check
    always @(posedge i_clk) begin
        aitp_pkg::t_result got;
        aitp_pkg::t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            out_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = aitp_pkg::t_status'(m_axis_tdata[2:0]);
                got.local_base = m_axis_tdata[66:3];
                got.cpu_count = m_axis_tdata[76:67];
                got.io_unit_id = m_axis_tdata[84:77];
                got.io_unit_base = m_axis_tdata[116:85];
                got.io_interrupt_base = m_axis_tdata[148:117];
                got.timer_override_seen = m_axis_tdata[149];
                got.timer_interrupt = m_axis_tdata[181:150];
                got.timer_override_flags = m_axis_tdata[197:182];
                if (summary_queue.size() == 0) begin
                    report_mismatch("unexpected transfer", 0, 0);
                end else begin
                    want = summary_queue.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.local_base != want.local_base)
                        report_mismatch("local_base", got.local_base, want.local_base);
                    if (got.cpu_count != want.cpu_count)
                        report_mismatch("cpu_count", 64'(got.cpu_count), 64'(want.cpu_count));
                    if (got.io_unit_id != want.io_unit_id)
                        report_mismatch("io_unit_id", 64'(got.io_unit_id),
                                        64'(want.io_unit_id));
                    if (got.io_unit_base != want.io_unit_base)
                        report_mismatch("io_unit_base", 64'(got.io_unit_base),
                                        64'(want.io_unit_base));
                    if (got.io_interrupt_base != want.io_interrupt_base)
                        report_mismatch("io_interrupt_base", 64'(got.io_interrupt_base),
                                        64'(want.io_interrupt_base));
                    if (got.timer_override_seen != want.timer_override_seen)
                        report_mismatch("timer_override_seen", 64'(got.timer_override_seen),
                                        64'(want.timer_override_seen));
                    if (got.timer_interrupt != want.timer_interrupt)
                        report_mismatch("timer_interrupt", 64'(got.timer_interrupt),
                                        64'(want.timer_interrupt));
                    if (got.timer_override_flags != want.timer_override_flags)
                        report_mismatch("timer_override_flags",
                                        64'(got.timer_override_flags),
                                        64'(want.timer_override_flags));
                end
                out_wait = $urandom_range(0, 16);
            end
            // hold ready low while the drawn wait count runs down
            if (out_wait > 0) begin
                m_axis_tready <= 1'b0;
                out_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        error_count = 0;
        items_sent = 0;
        clear_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_cpu_count();
        test_random_tables();
        s_axis_tvalid <= 1'b0;
        while (summary_queue.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
